// ===== rtl/ih_pkg.sv =====
// Shared constants, types and codes of the indexed min-heap.
`default_nettype none
package ih_pkg;
  localparam int NODE_BITS     = 10;
  localparam int CAPACITY      = 1024;
  localparam int PRIORITY_BITS = 32;
  localparam int SLOT_BITS     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int COUNT_BITS    = $clog2(CAPACITY + 1);
  localparam int IDX_W         = SLOT_BITS + 2;
  localparam int NODE_SPACE    = 1 << NODE_BITS;

  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_POP  = 2'd1;
  localparam logic [1:0] OP_DEC  = 2'd2;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_POP_EMPTY   = 3'd1;
  localparam logic [2:0] ST_PUSH_FULL   = 3'd2;
  localparam logic [2:0] ST_PRESENT     = 3'd3;
  localparam logic [2:0] ST_ABSENT      = 3'd4;
  localparam logic [2:0] ST_NOT_SMALLER = 3'd5;

  typedef struct packed {
    logic [NODE_BITS-1:0]     node;
    logic [PRIORITY_BITS-1:0] prio;
  } heap_ent_t;

  typedef struct packed {
    logic                 valid;
    logic [SLOT_BITS-1:0] slot;
  } map_ent_t;

  typedef struct packed {
    logic [2:0]               status;
    logic [NODE_BITS-1:0]     node;
    logic [PRIORITY_BITS-1:0] prio;
    logic                     present;
    logic [COUNT_BITS-1:0]    count;
    logic                     empty;
  } result_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MAP, S_DEC, S_UP, S_UP_CMP, S_POP_TOP, S_POP_LAST,
    S_DOWN, S_DN_L, S_DN_R, S_DONE
  } state_t;
endpackage
`default_nettype wire

// ===== rtl/indexed_min_heap.sv =====
// Top level of the indexed binary min-heap priority queue.
`default_nettype none
// Indexed min-heap of (node, priority) pairs for shortest-path search. One
// transaction on the in_ channel is one operation (push, pop minimum or
// decrease key) and yields exactly one result transaction on the out_ channel.
// Heap slots and the node-to-slot map live in two single-port-read RAMs with
// registered read data; the sequencer works on one operation at a time.
// An operation rejected at the map lookup ends there; a push or
// decrease-key climbs the tree with a parent read, a compare and a write per
// level, and a pop descends with a left read, right read, compare and write
// per level. The sift loops and their memory read port bound the cost. After
// reset a clearing pass marks every node absent in the map; in_ready stays
// low until it ends.
module indexed_min_heap (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output      logic                             in_ready,
  input  wire logic [1:0]                       in_op,
  input  wire logic [ih_pkg::NODE_BITS-1:0]     in_node_id,
  input  wire logic [ih_pkg::PRIORITY_BITS-1:0] in_priority_req,
  output      logic                             out_valid,
  input  wire logic                             out_ready,
  output      logic [2:0]                       out_status,
  output      logic [ih_pkg::NODE_BITS-1:0]     out_out_node,
  output      logic [ih_pkg::PRIORITY_BITS-1:0] out_out_priority,
  output      logic                             out_node_present,
  output      logic [ih_pkg::COUNT_BITS-1:0]    out_count,
  output      logic                             out_is_empty
);
  import ih_pkg::*;

  logic                 res_valid, res_ready;
  result_t              res;
  logic                 heap_we, map_we;
  logic [SLOT_BITS-1:0] heap_wa, heap_ra;
  heap_ent_t            heap_wd, heap_rd;
  logic [NODE_BITS-1:0] map_wa, map_ra;
  map_ent_t             map_wd, map_rd;
  logic                 out_valid_r;
  result_t              out_r;

  ih_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_op, .in_node_id, .in_priority_req,
    .res_valid, .res_ready, .res,
    .heap_we, .heap_wa, .heap_wd, .heap_ra, .heap_rd,
    .map_we, .map_wa, .map_wd, .map_ra, .map_rd
  );

  // Heap slots: node and priority per slot.
  ih_ram #(.WIDTH($bits(heap_ent_t)), .DEPTH(CAPACITY)) u_heap (
    .clk, .we(heap_we), .wa(heap_wa), .wd(heap_wd), .ra(heap_ra), .rd(heap_rd)
  );

  // Position map: valid bit and slot per node.
  ih_ram #(.WIDTH($bits(map_ent_t)), .DEPTH(NODE_SPACE)) u_map (
    .clk, .we(map_we), .wa(map_wa), .wd(map_wd), .ra(map_ra), .rd(map_rd)
  );

  // Output register: hold the result until the consumer takes it.
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
    if (res_ready && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_r.status;
  assign out_out_node     = out_r.node;
  assign out_out_priority = out_r.prio;
  assign out_node_present = out_r.present;
  assign out_count        = out_r.count;
  assign out_is_empty     = out_r.empty;
endmodule
`default_nettype wire

// ===== rtl/ih_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ih_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wa,
  input  wire logic [WIDTH-1:0]         wd,
  input  wire logic [$clog2(DEPTH)-1:0] ra,
  output      logic [WIDTH-1:0]         rd
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd <= mem[ra];
  end
endmodule
`default_nettype wire

// ===== rtl/ih_ctrl.sv =====
// Operation sequencer: map lookup, sift up and sift down over the two RAMs.
`default_nettype none
module ih_ctrl (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output      logic                             in_ready,
  input  wire logic [1:0]                       in_op,
  input  wire logic [ih_pkg::NODE_BITS-1:0]     in_node_id,
  input  wire logic [ih_pkg::PRIORITY_BITS-1:0] in_priority_req,
  output      logic                             res_valid,
  input  wire logic                             res_ready,
  output      ih_pkg::result_t                  res,
  output      logic                             heap_we,
  output      logic [ih_pkg::SLOT_BITS-1:0]     heap_wa,
  output      ih_pkg::heap_ent_t                heap_wd,
  output      logic [ih_pkg::SLOT_BITS-1:0]     heap_ra,
  input  wire ih_pkg::heap_ent_t                heap_rd,
  output      logic                             map_we,
  output      logic [ih_pkg::NODE_BITS-1:0]     map_wa,
  output      ih_pkg::map_ent_t                 map_wd,
  output      logic [ih_pkg::NODE_BITS-1:0]     map_ra,
  input  wire ih_pkg::map_ent_t                 map_rd
);
  import ih_pkg::*;

  state_t                   state_r, state_nxt;
  logic [1:0]               op_r, op_nxt;
  logic [NODE_BITS-1:0]     node_r, node_nxt;
  logic [PRIORITY_BITS-1:0] key_r, key_nxt;
  logic                     present_r, present_nxt;
  logic [COUNT_BITS-1:0]    cnt_r, cnt_nxt;
  logic [SLOT_BITS-1:0]     idx_r, idx_nxt;
  heap_ent_t                cur_r, cur_nxt;
  heap_ent_t                lft_r, lft_nxt;
  logic                     rv_r, rv_nxt;
  logic [2:0]               status_r, status_nxt;
  heap_ent_t                pop_r, pop_nxt;
  logic [NODE_BITS-1:0]     clr_r, clr_nxt;

  logic [IDX_W-1:0]     cnt_w, lidx, ridx;
  logic [SLOT_BITS-1:0] parent;
  logic                 take_l, take_r;
  heap_ent_t            best;
  logic [SLOT_BITS-1:0] best_idx;

  assign cnt_w  = IDX_W'(cnt_r);
  assign lidx   = IDX_W'({idx_r, 1'b1});
  assign ridx   = lidx + IDX_W'(1);
  assign parent = SLOT_BITS'((idx_r - SLOT_BITS'(1)) >> 1);

  always_comb begin
    take_l = (lft_r.prio < cur_r.prio);
    take_r = rv_r && (heap_rd.prio < (take_l ? lft_r.prio : cur_r.prio));
    priority if (take_r) begin
      best     = heap_rd;
      best_idx = ridx[SLOT_BITS-1:0];
    end else if (take_l) begin
      best     = lft_r;
      best_idx = lidx[SLOT_BITS-1:0];
    end else begin
      best     = cur_r;
      best_idx = idx_r;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:    if (clr_r == '1) state_nxt = S_IDLE;
      S_IDLE:     if (in_valid) state_nxt = S_MAP;
      S_MAP: begin
        unique case (op_r)
          OP_PUSH: state_nxt = (cnt_w >= IDX_W'(CAPACITY) || map_rd.valid) ? S_DONE : S_UP;
          OP_POP:  state_nxt = (cnt_r == '0) ? S_DONE : S_POP_TOP;
          OP_DEC:  state_nxt = (!map_rd.valid || IDX_W'(map_rd.slot) >= cnt_w) ? S_DONE : S_DEC;
          default: state_nxt = S_DONE;
        endcase
      end
      S_DEC:      state_nxt = (key_r >= heap_rd.prio) ? S_DONE : S_UP;
      S_UP:       state_nxt = (idx_r == '0) ? S_DONE : S_UP_CMP;
      S_UP_CMP:   state_nxt = (cur_r.prio < heap_rd.prio) ? S_UP : S_DONE;
      S_POP_TOP:  state_nxt = (cnt_r == COUNT_BITS'(1)) ? S_DONE : S_POP_LAST;
      S_POP_LAST: state_nxt = S_DOWN;
      S_DOWN:     state_nxt = (lidx >= cnt_w) ? S_DONE : S_DN_L;
      S_DN_L:     state_nxt = S_DN_R;
      S_DN_R:     state_nxt = (take_l || take_r) ? S_DOWN : S_DONE;
      S_DONE:     if (res_ready) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Datapath and memory ports.
  always_comb begin
    op_nxt      = op_r;
    node_nxt    = node_r;
    key_nxt     = key_r;
    present_nxt = present_r;
    cnt_nxt     = cnt_r;
    idx_nxt     = idx_r;
    cur_nxt     = cur_r;
    lft_nxt     = lft_r;
    rv_nxt      = rv_r;
    status_nxt  = status_r;
    pop_nxt     = pop_r;
    clr_nxt     = clr_r;
    in_ready    = 1'b0;
    res_valid   = 1'b0;
    heap_we     = 1'b0;
    heap_wa     = idx_r;
    heap_wd     = cur_r;
    heap_ra     = '0;
    map_we      = 1'b0;
    map_wa      = cur_r.node;
    map_wd      = '{valid: 1'b1, slot: idx_r};
    map_ra      = in_node_id;
    unique case (state_r)
      S_CLEAR: begin
        map_we  = 1'b1;
        map_wa  = clr_r;
        map_wd  = '0;
        clr_nxt = clr_r + NODE_BITS'(1);
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_nxt     = in_op;
          node_nxt   = in_node_id;
          key_nxt    = in_priority_req;
          status_nxt = ST_OK;
          pop_nxt    = '0;
        end
      end
      S_MAP: begin
        present_nxt = map_rd.valid;
        cur_nxt     = '{node: node_r, prio: key_r};
        unique case (op_r)
          OP_PUSH: begin
            if (cnt_w >= IDX_W'(CAPACITY)) begin
              status_nxt = ST_PUSH_FULL;
            end else if (map_rd.valid) begin
              status_nxt = ST_PRESENT;
            end else begin
              idx_nxt = cnt_r[SLOT_BITS-1:0];
              cnt_nxt = cnt_r + COUNT_BITS'(1);
            end
          end
          OP_POP: begin
            if (cnt_r == '0) status_nxt = ST_POP_EMPTY;
          end
          OP_DEC: begin
            if (!map_rd.valid || IDX_W'(map_rd.slot) >= cnt_w) begin
              status_nxt = ST_ABSENT;
            end else begin
              heap_ra = map_rd.slot;
              idx_nxt = map_rd.slot;
            end
          end
          default: ;
        endcase
      end
      S_DEC: begin
        if (key_r >= heap_rd.prio) status_nxt = ST_NOT_SMALLER;
      end
      S_UP: begin
        if (idx_r == '0) begin
          heap_we = 1'b1;
          map_we  = 1'b1;
        end else begin
          heap_ra = parent;
        end
      end
      S_UP_CMP: begin
        heap_we = 1'b1;
        map_we  = 1'b1;
        if (cur_r.prio < heap_rd.prio) begin
          heap_wd = heap_rd;
          map_wa  = heap_rd.node;
          idx_nxt = parent;
        end
      end
      S_POP_TOP: begin
        pop_nxt = heap_rd;
        map_we  = 1'b1;
        map_wa  = heap_rd.node;
        map_wd  = '0;
        cnt_nxt = cnt_r - COUNT_BITS'(1);
        heap_ra = SLOT_BITS'(cnt_r - COUNT_BITS'(1));
      end
      S_POP_LAST: begin
        cur_nxt = heap_rd;
        idx_nxt = '0;
      end
      S_DOWN: begin
        if (lidx >= cnt_w) begin
          heap_we = 1'b1;
          map_we  = 1'b1;
        end else begin
          heap_ra = lidx[SLOT_BITS-1:0];
        end
      end
      S_DN_L: begin
        lft_nxt = heap_rd;
        rv_nxt  = (ridx < cnt_w);
        heap_ra = ridx[SLOT_BITS-1:0];
      end
      S_DN_R: begin
        heap_we = 1'b1;
        heap_wd = best;
        map_we  = 1'b1;
        map_wa  = best.node;
        idx_nxt = best_idx;
      end
      S_DONE: res_valid = 1'b1;
      default: ;
    endcase
  end

  assign res = '{status: status_r, node: pop_r.node, prio: pop_r.prio,
                 present: present_r, count: cnt_r, empty: (cnt_r == '0)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      cnt_r   <= '0;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      clr_r   <= clr_nxt;
    end
    op_r      <= op_nxt;
    node_r    <= node_nxt;
    key_r     <= key_nxt;
    present_r <= present_nxt;
    idx_r     <= idx_nxt;
    cur_r     <= cur_nxt;
    lft_r     <= lft_nxt;
    rv_r      <= rv_nxt;
    status_r  <= status_nxt;
    pop_r     <= pop_nxt;
  end
endmodule
`default_nettype wire

// ===== rtl/ih_chk.sv =====
// Port-level checker for the indexed min-heap, bound to the top level.
`default_nettype none
module ih_chk (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             out_valid,
  input wire logic                             out_ready,
  input wire logic [2:0]                       out_status,
  input wire logic [ih_pkg::NODE_BITS-1:0]     out_out_node,
  input wire logic [ih_pkg::PRIORITY_BITS-1:0] out_out_priority,
  input wire logic [ih_pkg::COUNT_BITS-1:0]    out_count,
  input wire logic                             out_is_empty
);
  import ih_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_count))
    else $error("result dropped while stalled");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_is_empty == (out_count == '0))
    else $error("empty flag disagrees with count");

  a_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_count <= COUNT_BITS'(CAPACITY))
    else $error("count beyond capacity");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_out_node == '0 && out_out_priority == '0)
    else $error("rejected operation reports a node");
endmodule

bind indexed_min_heap ih_chk u_ih_chk (.*);
`default_nettype wire
